/* hw/rtl/qmm_pkg.sv */
// Package for the quadrotor motor mixer: word types, hand-off struct and constants.
// No dependencies.
`default_nettype none
package qmm_pkg;

   localparam int NUM_MOTORS = 4;
   localparam int ATT_W      = 34;
   localparam int NUM_W      = 35;
   localparam int MAG_W      = 36;
   localparam int M_W        = 36;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STAGES = MAG_W / DIV_BITS;
   localparam int FRONT_LAT  = 5;
   localparam int FRAC_SHIFT = 14;
   localparam logic signed [NUM_W-1:0] ONE_Q29 = 35'sd536870912;

   localparam logic [2:0] REG_MOTOR1 = 3'd0;
   localparam logic [2:0] REG_MOTOR2 = 3'd1;
   localparam logic [2:0] REG_MOTOR3 = 3'd2;
   localparam logic [2:0] REG_MOTOR4 = 3'd3;
   localparam logic [2:0] REG_COLL   = 3'd4;
   localparam logic [15:0] COLL_RESET = 16'd16384;

   typedef struct packed {
      logic signed [15:0] transverse_cmd;
      logic signed [15:0] longitudinal_cmd;
      logic signed [15:0] yaw_cmd;
      logic signed [15:0] collective_cmd;
   } cmd_type;

   typedef struct packed {
      logic [15:0] motor1_out;
      logic [15:0] motor2_out;
      logic [15:0] motor3_out;
      logic [15:0] motor4_out;
   } rsp_type;

   typedef struct packed {
      logic                                  valid;
      logic [NUM_MOTORS-1:0][ATT_W-1:0]      att;
      logic [NUM_W-1:0]                      num;
      logic [31:0]                           ck;
      logic [15:0]                           kc;
      logic                                  coll_neg;
      logic                                  fit;
      logic                                  neg;
      logic [MAG_W-1:0]                      mag;
   } hand_type;

   typedef struct packed {
      hand_type    h;
      logic [15:0] rem;
   } div_type;

endpackage
`default_nettype wire

/* hw/rtl/qmm_front.sv */
// Front part of the mixer: captures command words, forms attitude parts,
// largest attitude, headroom and collective product. Depends on qmm_pkg.
`default_nettype none
module qmm_front import qmm_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire cmd_type                     cmd,
   input  wire logic [NUM_MOTORS-1:0][47:0] gains,
   input  wire logic [15:0]                 kc,
   output hand_type                         ho
);

   logic    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   cmd_type cmd_ff;
   logic signed [31:0] prod_ff [NUM_MOTORS][3];
   logic signed [31:0] prod_in [NUM_MOTORS][3];
   logic [31:0] ck2_ff, ck3_ff, ck4_ff;
   logic [15:0] kc2_ff, kc3_ff, kc4_ff;
   logic cn2_ff, cn3_ff, cn4_ff;
   logic signed [ATT_W-1:0] att_ff [NUM_MOTORS];
   logic signed [ATT_W-1:0] att4_ff [NUM_MOTORS];
   logic signed [ATT_W-1:0] amax_ff, amax_in, m01, m23;
   hand_type ho_ff, ho_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
         prod_in[k][0] = cmd_ff.transverse_cmd   * $signed(gains[k][15:0]);
         prod_in[k][1] = cmd_ff.longitudinal_cmd * $signed(gains[k][31:16]);
         prod_in[k][2] = cmd_ff.yaw_cmd          * $signed(gains[k][47:32]);
      end
   end

   always_comb begin
      m01     = (att_ff[1] > att_ff[0]) ? att_ff[1] : att_ff[0];
      m23     = (att_ff[3] > att_ff[2]) ? att_ff[3] : att_ff[2];
      amax_in = (m23 > m01) ? m23 : m01;
   end

   always_comb begin
      logic signed [NUM_W-1:0] n;
      n = ONE_Q29 - {amax_ff[ATT_W-1], amax_ff};
      ho_in.valid    = v4_ff;
      for (int k = 0; k < NUM_MOTORS; k++) begin
         ho_in.att[k] = att4_ff[k];
      end
      ho_in.num      = n;
      ho_in.ck       = ck4_ff;
      ho_in.kc       = kc4_ff;
      ho_in.coll_neg = cn4_ff;
      ho_in.fit      = ($signed({{(NUM_W-32){ck4_ff[31]}}, ck4_ff}) <= n);
      ho_in.neg      = n[NUM_W-1];
      ho_in.mag      = n[NUM_W-1] ? (-{n[NUM_W-1], n}) : {1'b0, n};
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd;
      for (int k = 0; k < NUM_MOTORS; k++) begin
         for (int j = 0; j < 3; j++) begin
            prod_ff[k][j] <= prod_in[k][j];
         end
         att_ff[k]  <= ATT_W'(prod_ff[k][0]) + ATT_W'(prod_ff[k][1])
                       + ATT_W'(prod_ff[k][2]);
         att4_ff[k] <= att_ff[k];
      end
      ck2_ff  <= cmd_ff.collective_cmd * $signed(kc);
      kc2_ff  <= kc;
      cn2_ff  <= cmd_ff.collective_cmd[15];
      ck3_ff  <= ck2_ff;
      kc3_ff  <= kc2_ff;
      cn3_ff  <= cn2_ff;
      ck4_ff  <= ck3_ff;
      kc4_ff  <= kc3_ff;
      cn4_ff  <= cn3_ff;
      amax_ff <= amax_in;
      ho_ff   <= ho_in;
   end

   assign ho = '{valid: v5_ff, att: ho_ff.att, num: ho_ff.num, ck: ho_ff.ck,
                 kc: ho_ff.kc, coll_neg: ho_ff.coll_neg, fit: ho_ff.fit,
                 neg: ho_ff.neg, mag: ho_ff.mag};

endmodule
`default_nettype wire

/* hw/rtl/qmm_back.sv */
// Back part of the mixer: pipelined remainder of headroom by collective gain,
// then collective limiting, floor and saturation. Depends on qmm_pkg.
`default_nettype none
module qmm_back import qmm_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire hand_type ho,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   localparam logic [32:0] OUT_MAX = (33'd1 << SAMPLE_WIDTH) - 33'd1;

   div_type st [DIV_STAGES+1];
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   assign st[0] = '{h: ho, rem: 16'd0};

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      div_type nx_in;
      div_type st_ff;
      always_comb begin
         logic [15:0] r;
         logic [15:0] dvs;
         dvs = {1'b0, st[s].h.kc[14:0]};
         r   = st[s].rem;
         for (int b = 0; b < DIV_BITS; b++) begin
            r = {r[14:0], st[s].h.mag[MAG_W-1-s*DIV_BITS-b]};
            if (r >= dvs) begin
               r = r - dvs;
            end
         end
         nx_in         = st[s];
         nx_in.rem     = r;
         nx_in.h.valid = st[s].h.valid && !reset;
      end
      always_ff @(posedge clock) begin
         st_ff <= nx_in;
      end
      assign st[s+1] = st_ff;
   end

   always_comb begin
      hand_type h;
      logic [15:0] rf;
      logic signed [M_W-1:0] term;
      logic signed [M_W-1:0] m;
      logic [21:0] o;
      logic [32:0] sat;
      logic [15:0] outs [NUM_MOTORS];
      h  = st[DIV_STAGES].h;
      rf = (h.neg && st[DIV_STAGES].rem != 16'd0) ? (h.kc - st[DIV_STAGES].rem)
                                                   : st[DIV_STAGES].rem;
      if (!h.kc[15] && h.kc != 16'd0) begin
         if (h.fit) begin
            term = M_W'($signed(h.ck));
         end else begin
            term = M_W'($signed(h.num)) - $signed({20'd0, rf});
         end
      end else begin
         term = h.coll_neg ? M_W'($signed(h.ck)) : '0;
      end
      for (int k = 0; k < NUM_MOTORS; k++) begin
         m = M_W'($signed(h.att[k])) + term;
         o = m[M_W-1] ? 22'd0 : m[FRAC_SHIFT+21:FRAC_SHIFT];
         sat = ({11'd0, o} > OUT_MAX) ? OUT_MAX : {11'd0, o};
         outs[k] = sat[15:0];
      end
      rsp_in.motor1_out = outs[0];
      rsp_in.motor2_out = outs[1];
      rsp_in.motor3_out = outs[2];
      rsp_in.motor4_out = outs[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= st[DIV_STAGES].h.valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

/* hw/rtl/quadrotor_motor_mixer.sv */
// Top level of the quadrotor motor mixer: register file, front and back parts.
// Depends on qmm_pkg, qmm_front and qmm_back.
//
//   channel  ports                          handshake
//   req      start, busy, req_cmd           start && !busy
//   rsp      rsp_valid, rsp_data            one-cycle strobe
//   csr      csr_psel..csr_prdata           psel && penable && pready
//
// One word per cycle; busy stays low. From accept to strobe a word passes
// 5 front stages, 9 remainder stages (4 quotient bits each), one output stage.
// Synchronous active-high reset clears valid bits and gains and presets kc_ff.
// The receiver cannot stall; no backpressure path exists.
`default_nettype none
module quadrotor_motor_mixer import qmm_pkg::*; #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire cmd_type     req_cmd,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   logic [NUM_MOTORS-1:0][47:0] gains_ff;
   logic [15:0] kc_ff;
   logic [2:0]  idx;
   logic        wr;
   hand_type    ho;

   assign busy       = 1'b0;
   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[5:3];
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
         kc_ff    <= COLL_RESET;
      end else if (wr) begin
         unique case (idx)
            REG_MOTOR1: gains_ff[0] <= csr_pwdata[47:0];
            REG_MOTOR2: gains_ff[1] <= csr_pwdata[47:0];
            REG_MOTOR3: gains_ff[2] <= csr_pwdata[47:0];
            REG_MOTOR4: gains_ff[3] <= csr_pwdata[47:0];
            REG_COLL:   kc_ff       <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MOTOR1: csr_prdata = {16'd0, gains_ff[0]};
         REG_MOTOR2: csr_prdata = {16'd0, gains_ff[1]};
         REG_MOTOR3: csr_prdata = {16'd0, gains_ff[2]};
         REG_MOTOR4: csr_prdata = {16'd0, gains_ff[3]};
         REG_COLL:   csr_prdata = {48'd0, kc_ff};
         default:    csr_prdata = '0;
      endcase
   end

   qmm_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (start && !busy),
      .cmd    (req_cmd),
      .gains  (gains_ff),
      .kc     (kc_ff),
      .ho     (ho)
   );

   qmm_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .ho        (ho),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");
   a_from_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(ho.valid, DIV_STAGES + 1))
      else $error("result without front word");
   a_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, FRONT_LAT + DIV_STAGES + 1))
      else $error("result without accepted word");
`endif

endmodule
`default_nettype wire

/* test/quadrotor_motor_mixer_tb.sv */
// Testbench for quadrotor_motor_mixer: directed table of fixed results plus random
// words checked against an in-bench predictor. Depends on qmm_pkg and the RTL.
`timescale 1ns / 100ps
module quadrotor_motor_mixer_tb;
   import qmm_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   cmd_type     req_cmd = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   quadrotor_motor_mixer uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_cmd(req_cmd),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_psel(csr_psel),
      .csr_penable(csr_penable), .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always #1 clock = ~clock;

   logic [47:0] gains_q [4];
   logic [15:0] coll_gain_q;
   rsp_type     motor_expect_q [$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          words_sent = 0;
   int          words_checked = 0;
   int          send_idle_pct = 27;

   function automatic rsp_type mix_motors(cmd_type c);
      logic signed [63:0] att [4];
      logic signed [63:0] amax, kc, coll, limit, lim_c, m, o, num;
      logic [15:0] g;
      rsp_type r;
      att[0] = 0;
      for (int k = 0; k < 4; k++) begin
         att[k] = 0;
         g = gains_q[k][15:0];   att[k] += 64'(c.transverse_cmd) * 64'($signed(g));
         g = gains_q[k][31:16];  att[k] += 64'(c.longitudinal_cmd) * 64'($signed(g));
         g = gains_q[k][47:32];  att[k] += 64'(c.yaw_cmd) * 64'($signed(g));
      end
      amax = att[0];
      for (int k = 1; k < 4; k++) if (att[k] > amax) amax = att[k];
      kc = 64'($signed(coll_gain_q));
      coll = 64'(c.collective_cmd);
      if (kc > 0) begin
         num = (64'sd1 <<< 29) - amax;
         limit = num / kc;
         if ((num % kc) != 0 && num < 0) limit = limit - 1;
      end else begin
         limit = 0;
      end
      lim_c = (coll < limit) ? coll : limit;
      for (int k = 0; k < 4; k++) begin
         m = att[k] + lim_c * kc;
         o = (m < 0) ? 64'sd0 : (m >>> 14);
         if (o > 64'sd65535) o = 64'sd65535;
         case (k)
            0: r.motor1_out = o[15:0];
            1: r.motor2_out = o[15:0];
            2: r.motor3_out = o[15:0];
            default: r.motor4_out = o[15:0];
         endcase
      end
      return r;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (idx < REG_COLL) gains_q[idx] = val[47:0];
      else if (idx == REG_COLL) coll_gain_q = val[15:0];
   endtask

   task automatic send_word(input cmd_type c, input rsp_type want, input bit typed);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
      motor_expect_q.push_back(typed ? want : mix_motors(c));
      words_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (motor_expect_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_gains(input bit wide);
      logic [63:0] v;
      for (int k = 0; k < 4; k++) begin
         v = {$urandom, $urandom};
         if (!wide) v[47:0] = {16'($signed(14'($urandom))), 16'($signed(14'($urandom))),
                               16'($signed(14'($urandom)))};
         write_reg(3'(k), v);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            idle_cycles <= 0;
            if (motor_expect_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               errors++;
            end else begin
               want = motor_expect_q.pop_front();
               words_checked++;
               if (want.motor1_out != rsp_data.motor1_out ||
                   want.motor2_out != rsp_data.motor2_out ||
                   want.motor3_out != rsp_data.motor3_out ||
                   want.motor4_out != rsp_data.motor4_out) begin
                  $display("%0t: mismatch expected %h actual %h", $time, want, rsp_data);
                  errors++;
               end
            end
         end else if (start && !busy) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
               $display("%0t: watchdog timeout", $time);
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

   typedef struct {
      cmd_type c;
      rsp_type r;
      bit      typed;
   } stim_row_type;

   stim_row_type dir_tab [$];

   initial begin
      cmd_type c;
      logic [15:0] cg_list [6];
      cg_list = '{16'sd16384, 16'h7fff, 16'h8000, 16'd0, 16'd1, 16'hc000};
      for (int k = 0; k < 4; k++) gains_q[k] = '0;
      coll_gain_q = COLL_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      dir_tab.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 64'h4000400040004000, 1});
      dir_tab.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'h7fff}, 64'h7fff7fff7fff7fff, 1});
      dir_tab.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'h8000}, 64'h0, 1});
      dir_tab.push_back('{'{16'h7fff, 16'h8000, 16'h7fff, 16'sd0}, 64'h0, 1});
      foreach (dir_tab[i]) send_word(dir_tab[i].c, dir_tab[i].r, dir_tab[i].typed);
      drain();

      write_reg(REG_MOTOR1, 64'h0000_4000_4000_4000);
      write_reg(REG_MOTOR2, 64'h0000_c000_c000_4000);
      write_reg(REG_MOTOR3, 64'h0000_7fff_8000_8000);
      write_reg(REG_MOTOR4, 64'hffff_8000_7fff_7fff);
      write_reg(3'd5, 64'h1234);
      for (int g = 0; g < 4; g++) begin
         write_reg(REG_COLL, {48'hffff_ffff_ffff, cg_list[g]});
         send_word('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, '0, 0);
         send_word('{16'h8000, 16'h8000, 16'h8000, 16'h8000}, '0, 0);
         send_word('{16'h7fff, 16'h8000, 16'h0000, 16'h0001}, '0, 0);
         send_word('{16'h0001, 16'hffff, 16'h8000, 16'h7fff}, '0, 0);
         drain();
      end

      for (int ph = 0; ph < 12; ph++) begin
         send_idle_pct = (ph < 4) ? 27 : (ph < 8) ? 85 : 0;
         random_gains(ph % 3 == 0);
         write_reg(REG_COLL, (ph % 2) ? 64'($urandom) : 64'(cg_list[ph % 6]));
         for (int i = 0; i < 160; i++) begin
            c = {$urandom, $urandom};
            if ($urandom_range(3) == 0)
               c.transverse_cmd = 16'($urandom_range(1)) ? 16'h7fff : 16'h8000;
            if ($urandom_range(3) == 0)
               c.collective_cmd = 16'($urandom_range(1)) ? 16'h7fff : 16'h8000;
            send_word(c, '0, 0);
         end
         drain();
      end

      $display("Sent %0d command words, checked %0d results over 17 gain settings.",
               words_sent, words_checked);
      if (errors == 0 && motor_expect_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* quadrotor_motor_mixer.f */
hw/rtl/qmm_pkg.sv
hw/rtl/qmm_front.sv
hw/rtl/qmm_back.sv
hw/rtl/quadrotor_motor_mixer.sv
test/quadrotor_motor_mixer_tb.sv
